>>> rtl/core/gte_pkg.sv
package gte_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VID_W        = 6;
  localparam int CNT_W        = 7;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NEXT   = 2'd3;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef struct packed {
    logic             wr_en;
    logic [VID_W-1:0] wr_addr;
    row_t             wr_data;
    logic             rd_en;
    logic [VID_W-1:0] rd_addr;
  } row_req_t;

  typedef struct packed {
    logic             status;
    logic             edge_exists;
    logic             triangle_found;
    logic             enumeration_done;
    logic [VID_W-1:0] tri_first;
    logic [VID_W-1:0] tri_second;
    logic [VID_W-1:0] tri_third;
  } result_t;

endpackage

>>> rtl/core/gte_row_mem.sv
module gte_row_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  gte_pkg::row_req_t req,
  output gte_pkg::row_t     rd_data
);

  gte_pkg::row_t                      mem [gte_pkg::MAX_VERTICES];
  logic [gte_pkg::MAX_VERTICES-1:0]   row_vld_r;
  gte_pkg::row_t                      mem_q_r;
  logic                               vld_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[req.rd_addr];
    end
  end

  // a row never written reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      vld_q_r   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q_r <= row_vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

>>> rtl/core/graph_triangle_enumerator_unit.sv
// Triangle enumerator over an undirected graph of up to 64 vertices.
// Input channel (in_valid/in_ready) takes one command word: add, delete or
// query an edge, or ask for the next triangle. Every command gives exactly
// one result word on the output channel (out_valid/out_ready).
// Triangles come out one per request in lexicographic order; a done word
// ends the pass and the next request starts over. Add and delete restart it.
// in_ready is high only while the sequencer is idle; one command at a time.
// A rejected command reads no row; a query reads row a; add or delete rewrites
// row a, then row b. Next triangle walks the matrix one candidate vertex per
// cycle through a single row read port and one bit compare, so the time it
// takes grows with how far the next triangle lies from the cursor.
// The result is held in an output register; a stalled receiver holds it,
// and a command finishing meanwhile waits in its result state.
// cfg_wr_data sets the vertex count (reset 64); write only when idle.
// Reset (rst_n, synchronous) empties the graph at once, clears the cursor
// and drops any pending result word.
module graph_triangle_enumerator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic [gte_pkg::VID_W-1:0] in_vertex_a,
  input  logic [gte_pkg::VID_W-1:0] in_vertex_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_status,
  output logic                      out_edge_exists,
  output logic                      out_triangle_found,
  output logic                      out_enumeration_done,
  output logic [gte_pkg::VID_W-1:0] out_tri_first,
  output logic [gte_pkg::VID_W-1:0] out_tri_second,
  output logic [gte_pkg::VID_W-1:0] out_tri_third,
  input  logic                      cfg_wr_en,
  input  logic [gte_pkg::CNT_W-1:0] cfg_wr_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EA    = 3'd1;
  localparam logic [2:0] S_EB_RD = 3'd2;
  localparam logic [2:0] S_EB    = 3'd3;
  localparam logic [2:0] S_TI    = 3'd4;
  localparam logic [2:0] S_LI    = 3'd5;
  localparam logic [2:0] S_TJ    = 3'd6;
  localparam logic [2:0] S_TK    = 3'd7;
  localparam logic [2:0] S_RESP_UNUSED = 3'd0;

  logic [2:0]                state_r, state_nxt;
  logic                      resp_r, resp_nxt;
  logic [gte_pkg::CNT_W-1:0] vcount_r, vcount_nxt;
  logic [1:0]                cmd_r, cmd_nxt;
  logic [gte_pkg::VID_W-1:0] va_r, va_nxt, vb_r, vb_nxt;
  logic [gte_pkg::VID_W-1:0] cf_r, cf_nxt, cs_r, cs_nxt;
  logic [gte_pkg::CNT_W-1:0] ct_r, ct_nxt;
  logic [gte_pkg::CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  gte_pkg::row_t             row_i_r, row_i_nxt;
  gte_pkg::result_t          res_r, res_nxt, out_r, out_nxt;
  logic                      out_vld_r, out_vld_nxt;

  gte_pkg::row_req_t         req;
  gte_pkg::row_t             rd_data;
  logic [gte_pkg::CNT_W-1:0] n;
  logic [gte_pkg::CNT_W-1:0] j_first, k_first;
  logic                      acc;

  function automatic logic [gte_pkg::CNT_W-1:0] VCOUNT_MAX();
    return gte_pkg::CNT_W'(gte_pkg::MAX_VERTICES);
  endfunction

  gte_row_mem u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign n   = (vcount_r > VCOUNT_MAX()) ? VCOUNT_MAX() : vcount_r;
  assign acc = in_valid && in_ready;

  // start points of the inner scans, resuming from the cursor on its own row
  always_comb begin
    j_first = i_r + 7'd1;
    if ((i_r == {1'b0, cf_r}) && ({1'b0, cs_r} > j_first)) begin
      j_first = {1'b0, cs_r};
    end
    k_first = j_r + 7'd1;
    if ((i_r == {1'b0, cf_r}) && (j_r == {1'b0, cs_r}) && (ct_r > k_first)) begin
      k_first = ct_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    resp_nxt    = resp_r;
    vcount_nxt  = cfg_wr_en ? cfg_wr_data : vcount_r;
    cmd_nxt     = cmd_r;
    va_nxt      = va_r;
    vb_nxt      = vb_r;
    cf_nxt      = cf_r;
    cs_nxt      = cs_r;
    ct_nxt      = ct_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    row_i_nxt   = row_i_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ready;
    req         = '0;
    in_ready    = (state_r == S_IDLE) && !resp_r;

    if (resp_r) begin
      // hand the finished word to the output register once it is free
      if (!out_vld_r || out_ready) begin
        out_nxt     = res_r;
        out_vld_nxt = 1'b1;
        resp_nxt    = 1'b0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            cmd_nxt = in_command;
            va_nxt  = in_vertex_a;
            vb_nxt  = in_vertex_b;
            res_nxt = '0;
            if (in_command == gte_pkg::CMD_NEXT) begin
              i_nxt     = {1'b0, cf_r};
              state_nxt = S_TI;
            end else if (({1'b0, in_vertex_a} >= n) || ({1'b0, in_vertex_b} >= n)) begin
              res_nxt.status = 1'b1;
              resp_nxt       = 1'b1;
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = in_vertex_a;
              state_nxt   = S_EA;
            end
          end
        end
        S_EA: begin
          if (cmd_r == gte_pkg::CMD_QUERY) begin
            res_nxt.edge_exists = rd_data[vb_r];
            resp_nxt            = 1'b1;
            state_nxt           = S_IDLE;
          end else begin
            req.wr_en         = 1'b1;
            req.wr_addr       = va_r;
            req.wr_data       = rd_data;
            req.wr_data[vb_r] = (cmd_r == gte_pkg::CMD_ADD);
            state_nxt         = S_EB_RD;
          end
        end
        S_EB_RD: begin
          req.rd_en   = 1'b1;
          req.rd_addr = vb_r;
          state_nxt   = S_EB;
        end
        S_EB: begin
          req.wr_en         = 1'b1;
          req.wr_addr       = vb_r;
          req.wr_data       = rd_data;
          req.wr_data[va_r] = (cmd_r == gte_pkg::CMD_ADD);
          cf_nxt            = '0;
          cs_nxt            = '0;
          ct_nxt            = '0;
          resp_nxt          = 1'b1;
          state_nxt         = S_IDLE;
        end
        S_TI: begin
          if (i_r >= n) begin
            res_nxt.enumeration_done = 1'b1;
            cf_nxt    = '0;
            cs_nxt    = '0;
            ct_nxt    = '0;
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = i_r[gte_pkg::VID_W-1:0];
            j_nxt       = j_first;
            state_nxt   = S_LI;
          end
        end
        S_LI: begin
          row_i_nxt = rd_data;
          state_nxt = S_TJ;
        end
        S_TJ: begin
          if (j_r >= n) begin
            i_nxt     = i_r + 7'd1;
            state_nxt = S_TI;
          end else if (!row_i_r[j_r[gte_pkg::VID_W-1:0]]) begin
            j_nxt = j_r + 7'd1;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = j_r[gte_pkg::VID_W-1:0];
            k_nxt       = k_first;
            state_nxt   = S_TK;
          end
        end
        S_TK: begin
          // rd_data holds row j for the whole k walk
          if (k_r >= n) begin
            j_nxt     = j_r + 7'd1;
            state_nxt = S_TJ;
          end else if (row_i_r[k_r[gte_pkg::VID_W-1:0]] && rd_data[k_r[gte_pkg::VID_W-1:0]]) begin
            res_nxt.triangle_found = 1'b1;
            res_nxt.tri_first      = i_r[gte_pkg::VID_W-1:0];
            res_nxt.tri_second     = j_r[gte_pkg::VID_W-1:0];
            res_nxt.tri_third      = k_r[gte_pkg::VID_W-1:0];
            cf_nxt    = i_r[gte_pkg::VID_W-1:0];
            cs_nxt    = j_r[gte_pkg::VID_W-1:0];
            ct_nxt    = k_r + 7'd1;
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 7'd1;
          end
        end
        default: begin
          state_nxt = S_RESP_UNUSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      resp_r    <= 1'b0;
      vcount_r  <= gte_pkg::VCOUNT_RESET;
      cf_r      <= '0;
      cs_r      <= '0;
      ct_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      resp_r    <= resp_nxt;
      vcount_r  <= vcount_nxt;
      cf_r      <= cf_nxt;
      cs_r      <= cs_nxt;
      ct_r      <= ct_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    row_i_r <= row_i_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid            = out_vld_r;
  assign out_status           = out_r.status;
  assign out_edge_exists      = out_r.edge_exists;
  assign out_triangle_found   = out_r.triangle_found;
  assign out_enumeration_done = out_r.enumeration_done;
  assign out_tri_first        = out_r.tri_first;
  assign out_tri_second       = out_r.tri_second;
  assign out_tri_third        = out_r.tri_third;

endmodule

>>> tb/graph_triangle_enumerator_unit_checker.sv
`timescale 1ns / 1ps
module graph_triangle_enumerator_unit_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic [gte_pkg::VID_W-1:0] in_vertex_a,
  input  logic [gte_pkg::VID_W-1:0] in_vertex_b,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_status,
  input  logic                      out_edge_exists,
  input  logic                      out_triangle_found,
  input  logic                      out_enumeration_done,
  input  logic [gte_pkg::VID_W-1:0] out_tri_first,
  input  logic [gte_pkg::VID_W-1:0] out_tri_second,
  input  logic [gte_pkg::VID_W-1:0] out_tri_third,
  input  logic                      cfg_wr_en,
  input  logic [gte_pkg::CNT_W-1:0] cfg_wr_data,
  output int                        fail_count,
  output int                        words_owed
);

  gte_pkg::row_t             adj_rows [gte_pkg::MAX_VERTICES];
  logic [gte_pkg::VID_W-1:0] scan_first;
  logic [gte_pkg::VID_W-1:0] scan_second;
  logic [gte_pkg::CNT_W-1:0] scan_third;
  logic [gte_pkg::CNT_W-1:0] vertex_count = gte_pkg::VCOUNT_RESET;
  gte_pkg::result_t          expected_words [$];
  int                        mismatches = 0;

  function automatic int active_vertices();
    return (vertex_count < gte_pkg::MAX_VERTICES) ? int'(vertex_count) : gte_pkg::MAX_VERTICES;
  endfunction

  // Work out the answer to one command word and advance the graph and cursor.
  function automatic gte_pkg::result_t answer_command(logic [1:0] cmd,
                                                      logic [gte_pkg::VID_W-1:0] a,
                                                      logic [gte_pkg::VID_W-1:0] b);
    gte_pkg::result_t ans;
    int      n;
    int      i;
    int      j;
    int      k;
    int      j0;
    int      k0;
    bit      found;
    ans   = '0;
    n     = active_vertices();
    found = 1'b0;
    if (cmd == gte_pkg::CMD_NEXT) begin
      for (i = int'(scan_first); i < n && !found; i++) begin
        j0 = i + 1;
        if (i == int'(scan_first) && int'(scan_second) > j0) j0 = int'(scan_second);
        for (j = j0; j < n && !found; j++) begin
          if (adj_rows[i][j]) begin
            k0 = j + 1;
            if (i == int'(scan_first) && j == int'(scan_second) && int'(scan_third) > k0)
              k0 = int'(scan_third);
            for (k = k0; k < n && !found; k++) begin
              if (adj_rows[j][k] && adj_rows[i][k]) begin
                found              = 1'b1;
                ans.triangle_found = 1'b1;
                ans.tri_first      = i[gte_pkg::VID_W-1:0];
                ans.tri_second     = j[gte_pkg::VID_W-1:0];
                ans.tri_third      = k[gte_pkg::VID_W-1:0];
                scan_first         = i[gte_pkg::VID_W-1:0];
                scan_second        = j[gte_pkg::VID_W-1:0];
                scan_third         = gte_pkg::CNT_W'(k + 1);
              end
            end
          end
        end
      end
      if (!found) begin
        ans.enumeration_done = 1'b1;
        scan_first  = '0;
        scan_second = '0;
        scan_third  = '0;
      end
    end else if (int'(a) >= n || int'(b) >= n) begin
      ans.status = 1'b1;
    end else if (cmd == gte_pkg::CMD_QUERY) begin
      ans.edge_exists = adj_rows[a][b];
    end else begin
      adj_rows[a][b] = (cmd == gte_pkg::CMD_ADD);
      adj_rows[b][a] = (cmd == gte_pkg::CMD_ADD);
      scan_first  = '0;
      scan_second = '0;
      scan_third  = '0;
    end
    return ans;
  endfunction

  function automatic int field_differs(string name, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    gte_pkg::result_t seen;
    gte_pkg::result_t want;
    gte_pkg::result_t issued;
    if (!rst_n) begin
      for (int v = 0; v < gte_pkg::MAX_VERTICES; v++) adj_rows[v] = '0;
      scan_first   = '0;
      scan_second  = '0;
      scan_third   = '0;
      vertex_count = gte_pkg::VCOUNT_RESET;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) vertex_count = cfg_wr_data;
      if (in_valid && in_ready) begin
        issued = answer_command(in_command, in_vertex_a, in_vertex_b);
        expected_words.insert(expected_words.size(), issued);
      end
      if (out_valid && out_ready) begin
        seen.status           = out_status;
        seen.edge_exists      = out_edge_exists;
        seen.triangle_found   = out_triangle_found;
        seen.enumeration_done = out_enumeration_done;
        seen.tri_first        = out_tri_first;
        seen.tri_second       = out_tri_second;
        seen.tri_third        = out_tri_third;
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, actual %h",
                   $time, seen);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          mismatches += field_differs("status", int'(want.status), int'(seen.status));
          mismatches += field_differs("edge_exists", int'(want.edge_exists),
                                      int'(seen.edge_exists));
          mismatches += field_differs("triangle_found", int'(want.triangle_found),
                                      int'(seen.triangle_found));
          mismatches += field_differs("enumeration_done", int'(want.enumeration_done),
                                      int'(seen.enumeration_done));
          mismatches += field_differs("tri_first", int'(want.tri_first),
                                      int'(seen.tri_first));
          mismatches += field_differs("tri_second", int'(want.tri_second),
                                      int'(seen.tri_second));
          mismatches += field_differs("tri_third", int'(want.tri_third),
                                      int'(seen.tri_third));
        end
      end
    end
    words_owed <= expected_words.size();
    fail_count <= mismatches;
  end

endmodule

>>> tb/graph_triangle_enumerator_unit_test.sv
`timescale 1ns / 1ps
module graph_triangle_enumerator_unit_test;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int STALL_CYCLES   = 400;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_command = gte_pkg::CMD_QUERY;
  logic [gte_pkg::VID_W-1:0] in_vertex_a = '0;
  logic [gte_pkg::VID_W-1:0] in_vertex_b = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_status;
  logic                      out_edge_exists;
  logic                      out_triangle_found;
  logic                      out_enumeration_done;
  logic [gte_pkg::VID_W-1:0] out_tri_first;
  logic [gte_pkg::VID_W-1:0] out_tri_second;
  logic [gte_pkg::VID_W-1:0] out_tri_third;
  logic                      cfg_wr_en = 1'b0;
  logic [gte_pkg::CNT_W-1:0] cfg_wr_data = gte_pkg::VCOUNT_RESET;
  int                        fail_count;
  int                        words_owed;

  int                        send_idle = 0;
  int                        recv_idle = 0;
  bit                        stall_request = 1'b0;
  bit                        stall_done = 1'b0;
  int                        quiet_cycles = 0;
  logic [gte_pkg::CNT_W-1:0] vertex_setting = gte_pkg::VCOUNT_RESET;

  graph_triangle_enumerator_unit dut (.*);

  graph_triangle_enumerator_unit_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request && !stall_done) begin
        out_ready <= 1'b0;
        stall_done = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("graph_triangle_enumerator_unit_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [gte_pkg::VID_W-1:0] a,
                           logic [gte_pkg::VID_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_vertex_a <= a;
    in_vertex_b <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every result word has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [gte_pkg::VID_W-1:0] pick_vertex();
    int n;
    n = (vertex_setting < gte_pkg::MAX_VERTICES) ? int'(vertex_setting) : gte_pkg::MAX_VERTICES;
    if (n == 0 || $urandom_range(0, 9) == 0) return gte_pkg::VID_W'($urandom_range(0, 63));
    // keep large graphs dense near the top so triangles still turn up
    if (n == gte_pkg::MAX_VERTICES && $urandom_range(0, 1) == 1)
      return gte_pkg::VID_W'(56 + $urandom_range(0, 7));
    return gte_pkg::VID_W'($urandom_range(0, n - 1));
  endfunction

  task automatic random_phase(int items);
    int left;
    int pick;
    int burst;
    left = items;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_word(pick < 30 ? gte_pkg::CMD_ADD :
                  (pick < 42 ? gte_pkg::CMD_DELETE : gte_pkg::CMD_QUERY),
                  pick_vertex(), pick_vertex());
        left--;
      end else begin
        // walk part of the enumeration in one go
        burst = $urandom_range(1, 6);
        repeat (burst) send_word(gte_pkg::CMD_NEXT, gte_pkg::VID_W'($urandom_range(0, 63)),
                                 gte_pkg::VID_W'($urandom_range(0, 63)));
        left -= burst;
      end
    end
  endtask

  task automatic run_phase(logic [gte_pkg::CNT_W-1:0] count, int items);
    wait_idle();
    cfg_wr_data <= count;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    vertex_setting = count;
    random_phase(items);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 35;
    recv_idle = 58;

    send_word(gte_pkg::CMD_QUERY, 0, 0);
    send_word(gte_pkg::CMD_NEXT, 63, 63);
    send_word(gte_pkg::CMD_ADD, 0, 1);
    send_word(gte_pkg::CMD_ADD, 2, 1);
    send_word(gte_pkg::CMD_ADD, 0, 2);
    send_word(gte_pkg::CMD_ADD, 0, 2);
    send_word(gte_pkg::CMD_ADD, 5, 5);
    send_word(gte_pkg::CMD_QUERY, 5, 5);
    send_word(gte_pkg::CMD_NEXT, 0, 0);
    send_word(gte_pkg::CMD_NEXT, 0, 0);
    send_word(gte_pkg::CMD_NEXT, 0, 0);
    send_word(gte_pkg::CMD_ADD, 61, 62);
    send_word(gte_pkg::CMD_ADD, 63, 62);
    send_word(gte_pkg::CMD_ADD, 61, 63);
    send_word(gte_pkg::CMD_NEXT, 42, 21);
    send_word(gte_pkg::CMD_NEXT, 0, 0);
    send_word(gte_pkg::CMD_NEXT, 0, 0);
    send_word(gte_pkg::CMD_DELETE, 3, 4);
    send_word(gte_pkg::CMD_DELETE, 1, 0);
    send_word(gte_pkg::CMD_QUERY, 0, 1);
    send_word(gte_pkg::CMD_QUERY, 63, 61);
    send_word(gte_pkg::CMD_NEXT, 0, 0);
    send_word(gte_pkg::CMD_NEXT, 0, 0);

    run_phase(8, 20);
    stall_request = 1'b1;
    random_phase(90);
    run_phase(64, 30);
    run_phase(0, 15);

    send_idle = 58;
    recv_idle = 35;
    run_phase(5, 110);
    run_phase(127, 30);
    run_phase(1, 15);

    send_idle = 0;
    recv_idle = 0;
    run_phase(12, 130);
    run_phase(4, 90);
    run_phase(64, 30);

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("graph_triangle_enumerator_unit_test OK");
    end else begin
      $display("graph_triangle_enumerator_unit_test NOT OK");
    end
    $finish;
  end

endmodule
